// ===== rtl/pcxrle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrle_pkg
// shared types and constants of the pcx run-length image decoder
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  localparam int HEADER_LENGTH = 128;
  localparam int COORD_BITS    = 16;
  localparam int PLANES_OFFSET = 65;
  localparam int MAX_RUN       = 63;
  localparam int FIFO_DEPTH    = 4;

  localparam logic [15:0] COORD_MASK   = 16'((32'd1 << COORD_BITS) - 32'd1);
  localparam logic [7:0]  PCX_MAGIC    = 8'h0A;
  localparam logic [7:0]  PCX_VERSION  = 8'h05;
  localparam logic [7:0]  PCX_BPP      = 8'd8;
  localparam logic [7:0]  PCX_PLANES   = 8'd1;
  localparam logic [7:0]  THRESH_RESET = 8'd192;

  typedef enum logic [1:0] {
    STATUS_PIXEL      = 2'd0,
    STATUS_HEADER_OK  = 2'd1,
    STATUS_HEADER_BAD = 2'd2,
    STATUS_PLANES_BAD = 2'd3
  } status_t;

  // one command for the expander: count copies of the same result
  typedef struct packed {
    logic [7:0]  pixel_value;
    status_t     status;
    logic [16:0] image_width;
    logic [16:0] image_height;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [5:0]  count;
    logic        image_last;
  } cmd_t;

endpackage : pcxrle_pkg
`default_nettype wire

// ===== rtl/pcxrle_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrle_front
// header parser and run classifier, one file byte per cycle while the command queue has room
// ----------------------------------------------------------------------------
module pcxrle_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              byte_valid,
  output logic                   byte_ready,
  input  wire logic [7:0]        file_byte,
  input  wire logic              start_of_file,
  input  wire logic              q_full,
  output logic                   q_push,
  output pcxrle_pkg::cmd_t       q_data
);
  import pcxrle_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_HEADER, PH_HEADER_BAD, PH_DATA, PH_RUN, PH_DONE
  } phase_t;

  phase_t       phase, phase_next, eff_phase;
  logic [7:0]   byte_offset, byte_offset_next, off;
  logic [15:0]  header_words [4];
  logic [15:0]  word_next;
  logic         word_we;
  logic [1:0]   word_idx;
  logic [16:0]  img_w, img_h, ext_w, ext_h;
  logic [15:0]  xs, ys, xe, ye;
  logic [32:0]  pixels_remaining, pixels_next;
  logic [7:0]   pending_run_count, pending_next;
  logic [7:0]   run_thresh;
  logic         accept, bad;
  logic [5:0]   pend6, run_n;
  logic [33:0]  area;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;

  assign xs = header_words[0] & COORD_MASK;
  assign ys = header_words[1] & COORD_MASK;
  assign xe = header_words[2] & COORD_MASK;
  assign ye = header_words[3] & COORD_MASK;
  assign ext_w = (xe >= xs) ? ({1'b0, xe} - {1'b0, xs} + 17'd1) : 17'd0;
  assign ext_h = (ye >= ys) ? ({1'b0, ye} - {1'b0, ys} + 17'd1) : 17'd0;
  assign area  = img_w * img_h;

  assign pend6 = (pending_run_count > 8'(MAX_RUN)) ? 6'(MAX_RUN) : pending_run_count[5:0];
  assign run_n = (pixels_remaining < 33'(pend6)) ? pixels_remaining[5:0] : pend6;

  always_comb begin
    eff_phase        = start_of_file ? PH_HEADER : phase;
    off              = start_of_file ? 8'd0 : byte_offset;
    phase_next       = phase;
    byte_offset_next = byte_offset;
    pixels_next      = pixels_remaining;
    pending_next     = pending_run_count;
    word_we          = 1'b0;
    word_idx         = off[2:1] - 2'd2;
    word_next        = header_words[word_idx];
    bad              = 1'b0;
    q_push           = 1'b0;
    q_data           = '0;
    q_data.count     = 6'd1;
    if (accept) begin
      unique case (eff_phase)
        PH_HEADER, PH_HEADER_BAD: begin
          byte_offset_next = off + 8'd1;
          bad = (eff_phase == PH_HEADER_BAD) ||
                (off == 8'd0 && file_byte != PCX_MAGIC) ||
                (off == 8'd1 && file_byte != PCX_VERSION) ||
                (off == 8'd3 && file_byte != PCX_BPP);
          phase_next = bad ? PH_HEADER_BAD : PH_HEADER;
          if (off >= 8'd4 && off < 8'd12) begin
            word_we = 1'b1;
            if (!off[0]) word_next = {header_words[word_idx][15:8], file_byte};
            else         word_next = {file_byte, header_words[word_idx][7:0]};
          end
          if (off == 8'd3 && bad) begin
            phase_next    = PH_DONE;
            q_push        = 1'b1;
            q_data.status = STATUS_HEADER_BAD;
          end else if (off == 8'(PLANES_OFFSET) && file_byte != PCX_PLANES) begin
            phase_next    = PH_DONE;
            q_push        = 1'b1;
            q_data.status = STATUS_PLANES_BAD;
          end else if (off == 8'(HEADER_LENGTH - 1)) begin
            pixels_next         = area[32:0];
            phase_next          = (img_w == 17'd0 || img_h == 17'd0) ? PH_DONE : PH_DATA;
            q_push              = 1'b1;
            q_data.status       = STATUS_HEADER_OK;
            q_data.image_width  = img_w;
            q_data.image_height = img_h;
            q_data.origin_x     = xs;
            q_data.origin_y     = ys;
          end
        end
        PH_DATA: begin
          if (file_byte > run_thresh) begin
            pending_next = file_byte - run_thresh;
            phase_next   = PH_RUN;
          end else begin
            pixels_next        = pixels_remaining - 33'd1;
            q_push             = 1'b1;
            q_data.pixel_value = file_byte;
            q_data.image_last  = (pixels_remaining == 33'd1);
            if (pixels_remaining == 33'd1) phase_next = PH_DONE;
          end
        end
        PH_RUN: begin
          pixels_next        = pixels_remaining - 33'(run_n);
          pending_next       = 8'd0;
          q_push             = 1'b1;
          q_data.pixel_value = file_byte;
          q_data.count       = run_n;
          q_data.image_last  = (pixels_remaining == 33'(run_n));
          phase_next         = (pixels_remaining == 33'(run_n)) ? PH_DONE : PH_DATA;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    img_w <= ext_w;
    img_h <= ext_h;
    if (word_we) header_words[word_idx] <= word_next;
    if (rst) begin
      phase             <= PH_IDLE;
      byte_offset       <= 8'd0;
      pixels_remaining  <= '0;
      pending_run_count <= 8'd0;
      run_thresh        <= THRESH_RESET;
    end else begin
      phase             <= phase_next;
      byte_offset       <= byte_offset_next;
      pixels_remaining  <= pixels_next;
      pending_run_count <= pending_next;
      if (cfg_valid) run_thresh <= cfg_data;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    q_push |-> q_data.count != 6'd0) else $error("empty command");
  a_data_has_pixels: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA || phase == PH_RUN) |-> pixels_remaining != 33'd0)
    else $error("data phase with no pixels left");
`endif

endmodule : pcxrle_front
`default_nettype wire

// ===== rtl/pcxrle_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrle_cmd_fifo
// short command queue between parser and expander
// ----------------------------------------------------------------------------
module pcxrle_cmd_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  pcxrle_pkg::cmd_t      push_data,
  output logic                  full,
  input  wire logic             pop,
  output pcxrle_pkg::cmd_t      head,
  output logic                  not_empty
);
  import pcxrle_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);

  cmd_t            mem [FIFO_DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     fill;

  assign full      = (fill == (PW+1)'(FIFO_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      fill <= fill + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (PW+1)'(FIFO_DEPTH)) else $error("queue overfilled");
  a_fill_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop && !full) |=> fill == $past(fill) + (PW+1)'(1))
    else $error("fill count lost a push");
`endif

endmodule : pcxrle_cmd_fifo
`default_nettype wire

// ===== rtl/pcxrle_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcxrle_back
// run expander: turns each queued command into its result transfers
// ----------------------------------------------------------------------------
module pcxrle_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_valid,
  input  pcxrle_pkg::cmd_t      q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output pcxrle_pkg::cmd_t      res,
  output logic                  res_run_last,
  output logic                  res_image_last
);
  import pcxrle_pkg::*;

  cmd_t        active;
  logic        active_valid;
  logic [5:0]  count;
  logic        fire, last_one;

  assign fire           = active_valid && res_ready;
  assign last_one       = (count == 6'd1);
  assign q_pop          = q_valid && (!active_valid || (fire && last_one));
  assign res_valid      = active_valid;
  assign res            = active;
  assign res_run_last   = last_one;
  assign res_image_last = active.image_last && last_one;

  always_ff @(posedge clk) begin
    if (q_pop) active <= q_head;
    if (rst) begin
      active_valid <= 1'b0;
      count        <= 6'd0;
    end else if (q_pop) begin
      active_valid <= 1'b1;
      count        <= q_head.count;
    end else if (fire) begin
      if (last_one) active_valid <= 1'b0;
      count <= count - 6'd1;
    end
  end

`ifndef SYNTHESIS
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    active_valid |-> count != 6'd0) else $error("active command with no results");
  a_image_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    res_image_last |-> res_run_last) else $error("image end inside a run");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid && $stable(count))
    else $error("expander moved while stalled");
`endif

endmodule : pcxrle_back
`default_nettype wire

// ===== rtl/pcx_rle_image_decoder_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pcx_rle_image_decoder_top
// 8-bit pcx run-length image decoder
//
// s_axis carries the file one byte per transfer; s_axis_tuser marks byte zero
// of a new file and restarts the parser. m_axis gives one result per
// transfer: a header status (accepted, invalid, not single plane) with image
// size and origin, then the decoded pixels. tlast ends the results of one
// input byte, tuser[2] flags the final pixel of the image.
// cfg writes the run threshold (reset 192); cfg_ready is always high and
// writes are expected only while the decoder is idle.
// A result passes through the command queue and the expander's active
// register before it is presented. Throughput: one byte per cycle while the
// queue has room; a run of n pixels holds the expander for n results while
// the parser keeps taking bytes until the four-entry command queue fills.
// Reset clears the parser, queue and expander; bytes before a file start are
// ignored. When m_axis stalls the result holds and s_axis backs up once the
// queue is full.
// ----------------------------------------------------------------------------
module pcx_rle_image_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,       // run threshold
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // file_byte
  input  wire logic        s_axis_tuser,   // start_of_file
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // pixel_value, image_width, image_height, origin_x, origin_y, pad
  output logic [2:0]       m_axis_tuser,   // status, image_last
  output logic             m_axis_tlast    // run_last
);
  import pcxrle_pkg::*;

  cmd_t  push_data, head, res;
  logic  push, full, pop, not_empty, run_last, image_last;

  assign cfg_ready = 1'b1;

  pcxrle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .byte_valid    (s_axis_tvalid),
    .byte_ready    (s_axis_tready),
    .file_byte     (s_axis_tdata),
    .start_of_file (s_axis_tuser),
    .q_full        (full),
    .q_push        (push),
    .q_data        (push_data)
  );

  pcxrle_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  pcxrle_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (not_empty),
    .q_head         (head),
    .q_pop          (pop),
    .res_valid      (m_axis_tvalid),
    .res_ready      (m_axis_tready),
    .res            (res),
    .res_run_last   (run_last),
    .res_image_last (image_last)
  );

  assign m_axis_tdata = {6'd0, res.origin_y, res.origin_x, res.image_height,
                         res.image_width, res.pixel_value};
  assign m_axis_tuser = {image_last, res.status};
  assign m_axis_tlast = run_last;

endmodule : pcx_rle_image_decoder_top
`default_nettype wire
